### design/tsrs_pkg.sv
package tsrs_pkg;

  localparam int unsigned QUEUE_DEPTH_C     = 64;
  localparam int unsigned STATIONS_C        = 16;
  localparam int unsigned MAX_FRAME_SLOTS_C = 16;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CFP_LENGTH  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIFS        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 8'd3;

  localparam logic [1:0] OP_LOCAL_DATA = 2'd0;
  localparam logic [1:0] OP_RX_REQUEST = 2'd1;
  localparam logic [1:0] OP_BEACON     = 2'd2;
  localparam logic [1:0] OP_UNUSED     = 2'd3;

  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_BEACON = 1'b1;

  localparam logic [19:0] SLOT_LENGTH_RST = 20'd10000;
  localparam logic [19:0] CFP_LENGTH_RST  = 20'd70000;
  localparam logic [9:0]  SIFS_RST        = 10'd16;

  typedef struct packed {
    logic [19:0] slot_length_us;
    logic [19:0] cfp_length_us;
    logic [9:0]  sifs_us;
    logic [47:0] own_address;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [47:0] requester;
    logic [47:0] ack_station;
    logic [19:0] data_duration_us;
    logic [19:0] ack_duration_us;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic        new_data_slot;
    logic        new_ack_slot;
    logic [4:0]  slot_count;
    logic [3:0]  slot_index;
    logic [47:0] slot_station;
    logic        last;
    logic        overflow;
  } rsp_t;

endpackage

### design/tsrs_req_if.sv
interface tsrs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [47:0] requester;
  logic [47:0] ack_station;
  logic [19:0] data_duration_us;
  logic [19:0] ack_duration_us;

  modport source (output valid, opcode, requester, ack_station, data_duration_us,
                  ack_duration_us, input ready);
  modport sink (input valid, opcode, requester, ack_station, data_duration_us,
                ack_duration_us, output ready);
endinterface

### design/tsrs_rsp_if.sv
interface tsrs_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        new_data_slot;
  logic        new_ack_slot;
  logic [4:0]  slot_count;
  logic [3:0]  slot_index;
  logic [47:0] slot_station;
  logic        last;
  logic        overflow;

  modport source (output valid, kind, new_data_slot, new_ack_slot, slot_count, slot_index,
                  slot_station, last, overflow, input ready);
  modport sink (input valid, kind, new_data_slot, new_ack_slot, slot_count, slot_index,
                slot_station, last, overflow, output ready);
endinterface

### design/tsrs_cfg_if.sv
interface tsrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/tsrs_ram.sv
module tsrs_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### design/tsrs_core.sv
module tsrs_core #(
  parameter int unsigned QUEUE_DEPTH     = 64,
  parameter int unsigned STATIONS        = 16,
  parameter int unsigned MAX_FRAME_SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tsrs_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tsrs_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tsrs_pkg::rsp_t out_rsp_o
);
  import tsrs_pkg::*;

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QLW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SAW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int unsigned SCW = $clog2(STATIONS + 1);
  localparam int unsigned PW  = QLW + 21;
  localparam int unsigned CW  = (PW > 33) ? PW + 1 : 34;
  localparam int unsigned MW  = QLW + 20;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_FIND  = 5'd1;
  localparam logic [4:0] S_CRD   = 5'd2;
  localparam logic [4:0] S_CCMP  = 5'd3;
  localparam logic [4:0] S_APP   = 5'd4;
  localparam logic [4:0] S_RES   = 5'd5;
  localparam logic [4:0] S_RDONE = 5'd6;
  localparam logic [4:0] S_MUL   = 5'd7;
  localparam logic [4:0] S_MCHK  = 5'd8;
  localparam logic [4:0] S_MRD   = 5'd9;
  localparam logic [4:0] S_MCMP  = 5'd10;
  localparam logic [4:0] S_SRD   = 5'd11;
  localparam logic [4:0] S_SWR   = 5'd12;
  localparam logic [4:0] S_ANS   = 5'd13;
  localparam logic [4:0] S_AWAIT = 5'd14;
  localparam logic [4:0] S_BLIM  = 5'd15;
  localparam logic [4:0] S_BCHK  = 5'd16;
  localparam logic [4:0] S_PRD   = 5'd17;
  localparam logic [4:0] S_PGET  = 5'd18;
  localparam logic [4:0] S_PFIND = 5'd19;
  localparam logic [4:0] S_PEMIT = 5'd20;
  localparam logic [4:0] S_PWAIT = 5'd21;

  logic [4:0]     state_q, state_d;
  logic [1:0]     op_q, op_d;
  logic [47:0]    ack_q, ack_d;
  logic [19:0]    adur_q, adur_d;
  logic           phase_q, phase_d;
  logic [47:0]    addr_q, addr_d;
  logic [20:0]    dsum_q, dsum_d;
  logic [SCW-1:0] sidx_q, sidx_d;
  logic [SAW-1:0] idx_q, idx_d;
  logic [QLW-1:0] i_q, i_d;
  logic [PW-1:0]  prod_q, prod_d;
  logic [31:0]    res_q, res_d;
  logic           added_q, added_d;
  logic           nd_q, nd_d;
  logic           ovf_q, ovf_d;
  logic [QLW-1:0] n_q, n_d;
  logic [QLW-1:0] k_q, k_d;
  logic [47:0]    st_q, st_d;
  logic [MW-1:0]  lenslot_q, lenslot_d;
  logic [QAW-1:0] head_q, head_d;
  logic [QLW-1:0] len_q, len_d;
  logic [SCW-1:0] scnt_q, scnt_d;
  logic           out_valid_q, out_valid_d;
  rsp_t           out_q, out_d;

  logic [47:0]    sta_addr_q [STATIONS];
  logic [31:0]    sta_res_q [STATIONS];
  logic           sta_awe, sta_rwe;
  logic [SAW-1:0] sta_aidx, sta_ridx;
  logic [31:0]    sta_rval;

  logic           ram_we;
  logic [QAW-1:0] ram_waddr, ram_raddr;
  logic [47:0]    ram_wdata, ram_rdata;

  logic [19:0]    slot;
  logic [32:0]    need;
  logic [32:0]    rsum;
  logic [47:0]    sta_rd_addr;
  logic [31:0]    sta_rd_res;

  function automatic logic [QAW-1:0] phys(input logic [QAW-1:0] head,
                                          input logic [QLW-1:0] x);
    logic [QLW:0] s;
    s = (QLW + 1)'(head) + (QLW + 1)'(x);
    if (s >= (QLW + 1)'(QUEUE_DEPTH)) begin
      s = s - (QLW + 1)'(QUEUE_DEPTH);
    end
    return s[QAW-1:0];
  endfunction

  tsrs_ram #(.WIDTH(48), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign slot        = (cfg_i.slot_length_us == '0) ? 20'd1 : cfg_i.slot_length_us;
  assign need        = 33'(dsum_q) + 33'(res_q);
  assign rsum        = 33'(res_q) + 33'(dsum_q);
  assign sta_rd_addr = sta_addr_q[sidx_q[SAW-1:0]];
  assign sta_rd_res  = sta_res_q[sidx_q[SAW-1:0]];

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ack_d       = ack_q;
    adur_d      = adur_q;
    phase_d     = phase_q;
    addr_d      = addr_q;
    dsum_d      = dsum_q;
    sidx_d      = sidx_q;
    idx_d       = idx_q;
    i_d         = i_q;
    prod_d      = prod_q;
    res_d       = res_q;
    added_d     = added_q;
    nd_d        = nd_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    k_d         = k_q;
    st_d        = st_q;
    lenslot_d   = lenslot_q;
    head_d      = head_q;
    len_d       = len_q;
    scnt_d      = scnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    sta_awe     = 1'b0;
    sta_rwe     = 1'b0;
    sta_aidx    = idx_q;
    sta_ridx    = idx_q;
    sta_rval    = '0;
    ram_we      = 1'b0;
    ram_waddr   = phys(head_q, len_q);
    ram_wdata   = addr_q;
    ram_raddr   = phys(head_q, i_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !out_valid_q) begin
          op_d    = in_req_i.opcode;
          ack_d   = in_req_i.ack_station;
          adur_d  = in_req_i.ack_duration_us;
          phase_d = 1'b0;
          ovf_d   = 1'b0;
          added_d = 1'b0;
          sidx_d  = '0;
          addr_d  = (in_req_i.opcode == OP_LOCAL_DATA) ? cfg_i.own_address
                                                       : in_req_i.requester;
          dsum_d  = 21'(in_req_i.data_duration_us) + 21'(cfg_i.sifs_us);
          k_d     = '0;
          prod_d  = '0;
          if (in_req_i.opcode == OP_BEACON) begin
            state_d = S_BLIM;
          end else if (in_req_i.opcode == OP_LOCAL_DATA ||
                       in_req_i.opcode == OP_RX_REQUEST) begin
            state_d = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (sidx_q == scnt_q) begin
          if (scnt_q >= SCW'(STATIONS)) begin
            ovf_d   = 1'b1;
            state_d = S_RDONE;
          end else begin
            sta_awe  = 1'b1;
            sta_rwe  = 1'b1;
            sta_aidx = scnt_q[SAW-1:0];
            sta_ridx = scnt_q[SAW-1:0];
            idx_d    = scnt_q[SAW-1:0];
            res_d    = '0;
            scnt_d   = scnt_q + SCW'(1);
            i_d      = '0;
            prod_d   = '0;
            state_d  = S_CRD;
          end
        end else if (sta_rd_addr == addr_q) begin
          idx_d   = sidx_q[SAW-1:0];
          res_d   = sta_rd_res;
          i_d     = '0;
          prod_d  = '0;
          state_d = S_CRD;
        end else begin
          sidx_d = sidx_q + SCW'(1);
        end
      end
      S_CRD: begin
        state_d = (i_q == len_q) ? S_APP : S_CCMP;
      end
      S_CCMP: begin
        if (ram_rdata == addr_q) begin
          prod_d = prod_q + PW'(slot);
        end
        i_d     = i_q + QLW'(1);
        state_d = S_CRD;
      end
      S_APP: begin
        if (CW'(prod_q) < CW'(need)) begin
          if (len_q >= QLW'(QUEUE_DEPTH)) begin
            ovf_d   = 1'b1;
            state_d = S_RES;
          end else begin
            ram_we  = 1'b1;
            len_d   = len_q + QLW'(1);
            prod_d  = prod_q + PW'(slot);
            added_d = 1'b1;
          end
        end else begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        sta_rwe  = 1'b1;
        sta_rval = rsum[32] ? 32'hFFFF_FFFF : rsum[31:0];
        state_d  = S_RDONE;
      end
      S_RDONE: begin
        if (!phase_q) begin
          nd_d    = added_q;
          phase_d = 1'b1;
          addr_d  = ack_q;
          dsum_d  = 21'(adur_q) + 21'(cfg_i.sifs_us);
          added_d = 1'b0;
          sidx_d  = '0;
          state_d = S_FIND;
        end else begin
          state_d = (nd_q && !added_q) ? S_MUL : S_ANS;
        end
      end
      S_MUL: begin
        lenslot_d = MW'(len_q) * MW'(slot);
        state_d   = S_MCHK;
      end
      S_MCHK: begin
        i_d = len_q;
        if (op_q == OP_LOCAL_DATA || lenslot_q <= MW'(cfg_i.cfp_length_us)) begin
          state_d = S_MRD;
        end else begin
          state_d = S_ANS;
        end
      end
      S_MRD: begin
        ram_raddr = phys(head_q, i_q - QLW'(1));
        state_d   = (i_q == '0) ? S_ANS : S_MCMP;
      end
      S_MCMP: begin
        i_d = i_q - QLW'(1);
        if (ram_rdata == ack_q) begin
          state_d = S_SRD;
        end else begin
          state_d = S_MRD;
        end
      end
      S_SRD: begin
        ram_raddr = phys(head_q, i_q + QLW'(1));
        if ((i_q + QLW'(1)) >= len_q) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_q, i_q);
          ram_wdata = ack_q;
          state_d   = S_ANS;
        end else begin
          state_d = S_SWR;
        end
      end
      S_SWR: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_q, i_q);
        ram_wdata = ram_rdata;
        i_d       = i_q + QLW'(1);
        state_d   = S_SRD;
      end
      S_ANS: begin
        out_valid_d         = 1'b1;
        out_d.kind          = KIND_ANSWER;
        out_d.new_data_slot = nd_q;
        out_d.new_ack_slot  = added_q;
        out_d.slot_count    = '0;
        out_d.slot_index    = '0;
        out_d.slot_station  = '0;
        out_d.last          = 1'b1;
        out_d.overflow      = ovf_q;
        state_d             = S_AWAIT;
      end
      S_AWAIT: begin
        if (out_valid_q && out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_BLIM: begin
        if ((32'(k_q) < 32'(len_q)) && (32'(k_q) < 32'(MAX_FRAME_SLOTS)) &&
            (prod_q + PW'(slot) <= PW'(cfg_i.cfp_length_us))) begin
          k_d    = k_q + QLW'(1);
          prod_d = prod_q + PW'(slot);
        end else begin
          n_d     = k_q;
          state_d = S_BCHK;
        end
      end
      S_BCHK: begin
        k_d = '0;
        if (n_q == '0) begin
          out_valid_d         = 1'b1;
          out_d.kind          = KIND_BEACON;
          out_d.new_data_slot = 1'b0;
          out_d.new_ack_slot  = 1'b0;
          out_d.slot_count    = '0;
          out_d.slot_index    = '0;
          out_d.slot_station  = '0;
          out_d.last          = 1'b1;
          out_d.overflow      = 1'b0;
          state_d             = S_AWAIT;
        end else begin
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        ram_raddr = head_q;
        state_d   = S_PGET;
      end
      S_PGET: begin
        st_d    = ram_rdata;
        head_d  = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QAW'(1);
        len_d   = len_q - QLW'(1);
        sidx_d  = '0;
        state_d = S_PFIND;
      end
      S_PFIND: begin
        if (sidx_q == scnt_q) begin
          state_d = S_PEMIT;
        end else if (sta_rd_addr == st_q) begin
          sta_rwe  = 1'b1;
          sta_ridx = sidx_q[SAW-1:0];
          sta_rval = (sta_rd_res > 32'(slot)) ? sta_rd_res - 32'(slot) : '0;
          state_d  = S_PEMIT;
        end else begin
          sidx_d = sidx_q + SCW'(1);
        end
      end
      S_PEMIT: begin
        out_valid_d         = 1'b1;
        out_d.kind          = KIND_BEACON;
        out_d.new_data_slot = 1'b0;
        out_d.new_ack_slot  = 1'b0;
        out_d.slot_count    = 5'(n_q);
        out_d.slot_index    = 4'(k_q);
        out_d.slot_station  = st_q;
        out_d.last          = ((k_q + QLW'(1)) == n_q);
        out_d.overflow      = 1'b0;
        state_d             = S_PWAIT;
      end
      S_PWAIT: begin
        if (out_valid_q && out_ready_i) begin
          k_d     = k_q + QLW'(1);
          state_d = ((k_q + QLW'(1)) == n_q) ? S_IDLE : S_PRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      len_q       <= '0;
      scnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      len_q       <= len_d;
      scnt_q      <= scnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    ack_q     <= ack_d;
    adur_q    <= adur_d;
    phase_q   <= phase_d;
    addr_q    <= addr_d;
    dsum_q    <= dsum_d;
    sidx_q    <= sidx_d;
    idx_q     <= idx_d;
    i_q       <= i_d;
    prod_q    <= prod_d;
    res_q     <= res_d;
    added_q   <= added_d;
    nd_q      <= nd_d;
    ovf_q     <= ovf_d;
    n_q       <= n_d;
    k_q       <= k_d;
    st_q      <= st_d;
    lenslot_q <= lenslot_d;
    out_q     <= out_d;
    if (sta_awe) begin
      sta_addr_q[sta_aidx] <= addr_q;
    end
    if (sta_rwe) begin
      sta_res_q[sta_ridx] <= sta_rval;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while a result is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= QLW'(QUEUE_DEPTH))
    else $error("slot queue length beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scnt_q <= SCW'(STATIONS))
    else $error("station count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_rsp_o.last) |=> (state_q == S_IDLE))
    else $error("sequencer busy after last result");
endmodule

### design/tdma_slot_reservation_scheduler.sv
// TDMA slot scheduler: one request at a time. For each of its two stations a reservation
// searches the station table, scans the queued slots and appends slots as needed; it can
// then move the ACK slot to the end of the queue. A beacon first sizes the schedule and then
// pops and emits one slot at a time, taking each popped slot off its station's reservation.
// Output stalls hold the block. The one-read-per-cycle slot queue RAM and the sequential
// station table compare set the pace of these steps. The block is ready again once its last
// result has been taken.
module tdma_slot_reservation_scheduler #(
  parameter int unsigned QUEUE_DEPTH     = tsrs_pkg::QUEUE_DEPTH_C,
  parameter int unsigned STATIONS        = tsrs_pkg::STATIONS_C,
  parameter int unsigned MAX_FRAME_SLOTS = tsrs_pkg::MAX_FRAME_SLOTS_C
) (
  input logic         clk_i,
  input logic         rst_ni,
  tsrs_req_if.sink    in_i,
  tsrs_rsp_if.source  out_o,
  tsrs_cfg_if.sink    cfg_i
);
  import tsrs_pkg::*;

  cfg_t cfg_q;
  req_t req;
  rsp_t rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_length_us <= SLOT_LENGTH_RST;
      cfg_q.cfp_length_us  <= CFP_LENGTH_RST;
      cfg_q.sifs_us        <= SIFS_RST;
      cfg_q.own_address    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SLOT_LENGTH: cfg_q.slot_length_us <= cfg_i.data[19:0];
        CFG_CFP_LENGTH:  cfg_q.cfp_length_us  <= cfg_i.data[19:0];
        CFG_SIFS:        cfg_q.sifs_us        <= cfg_i.data[9:0];
        CFG_OWN_ADDRESS: cfg_q.own_address    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  assign req.opcode           = in_i.opcode;
  assign req.requester        = in_i.requester;
  assign req.ack_station      = in_i.ack_station;
  assign req.data_duration_us = in_i.data_duration_us;
  assign req.ack_duration_us  = in_i.ack_duration_us;

  tsrs_core #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .STATIONS        (STATIONS),
    .MAX_FRAME_SLOTS (MAX_FRAME_SLOTS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_req_i    (req),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_rsp_o   (rsp)
  );

  assign out_o.kind          = rsp.kind;
  assign out_o.new_data_slot = rsp.new_data_slot;
  assign out_o.new_ack_slot  = rsp.new_ack_slot;
  assign out_o.slot_count    = rsp.slot_count;
  assign out_o.slot_index    = rsp.slot_index;
  assign out_o.slot_station  = rsp.slot_station;
  assign out_o.last          = rsp.last;
  assign out_o.overflow      = rsp.overflow;
endmodule
